// ===== rtl/core/iem_pkg.sv =====
// shared types and constants of the i2c eeprom master
package iem_pkg;

    // command codes
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_BYTE_WR = 3'd1;
    localparam logic [2:0] OP_PAGE_WR = 3'd2;
    localparam logic [2:0] OP_READ    = 3'd3;
    localparam logic [2:0] OP_LOAD    = 3'd4;

    // latched command codes
    localparam logic [1:0] CMD_BYTE_WR = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd3;

    // configuration register indexes
    localparam int          CFG_IDX_W       = 1;
    localparam int          CFG_DATA_W      = 15;
    localparam logic [0:0]  CFG_DEV_ADDR    = 1'b0;
    localparam logic [0:0]  CFG_ACK_TIMEOUT = 1'b1;

    localparam logic [6:0]  DEV_ADDR_RST    = 7'd80;
    localparam logic [14:0] ACK_TIMEOUT_RST = 15'd1000;

    // failure kinds
    localparam logic [1:0] FAIL_NONE    = 2'd0;
    localparam logic [1:0] FAIL_TIMEOUT = 2'd1;
    localparam logic [1:0] FAIL_NACK    = 2'd2;

    // one input tick
    typedef struct packed {
        logic [2:0] op;
        logic [7:0] word_addr;
        logic [7:0] wr_data;
        logic [2:0] page_index;
        logic [8:0] read_len;
        logic       sda_in;
    } iem_item_t;

    // bus sequencer phases
    typedef enum logic [21:0] {
        PH_IDLE = 22'h000001,
        PH_STA  = 22'h000002,
        PH_STB  = 22'h000004,
        PH_STC  = 22'h000008,
        PH_STD  = 22'h000010,
        PH_TXD  = 22'h000020,
        PH_TXH  = 22'h000040,
        PH_TXL  = 22'h000080,
        PH_TXE1 = 22'h000100,
        PH_TXE2 = 22'h000200,
        PH_AKW  = 22'h000400,
        PH_AKH  = 22'h000800,
        PH_AKL  = 22'h001000,
        PH_SPA  = 22'h002000,
        PH_SPB  = 22'h004000,
        PH_SPC  = 22'h008000,
        PH_RXR  = 22'h010000,
        PH_RXH  = 22'h020000,
        PH_RXL  = 22'h040000,
        PH_RXA  = 22'h080000,
        PH_RXAH = 22'h100000,
        PH_RXAL = 22'h200000
    } phase_t;

endpackage

// ===== rtl/core/iem_if.sv =====
// request channels of the i2c eeprom master
interface iem_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] word_addr;
    logic [7:0] wr_data;
    logic [2:0] page_index;
    logic [8:0] read_len;
    logic       sda_in;

    modport source (output valid, op, word_addr, wr_data, page_index, read_len, sda_in,
                    input ready);
    modport sink   (input valid, op, word_addr, wr_data, page_index, read_len, sda_in,
                    output ready);
endinterface

interface iem_result_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       rd_valid;
    logic [7:0] rd_data;
    logic       rd_last;
    logic       done_res;
    logic [3:0] status;
    logic [1:0] fail_kind;

    modport source (output valid, scl_out, sda_out, busy_res, rd_valid, rd_data, rd_last,
                    done_res, status, fail_kind, input ready);
    modport sink   (input valid, scl_out, sda_out, busy_res, rd_valid, rd_data, rd_last,
                    done_res, status, fail_kind, output ready);
endinterface

// ===== rtl/core/iem_front.sv =====
// front end: accepts ticks into a two-entry queue
module iem_front (
    input  logic              clk,
    input  logic              rst_n,
    iem_item_if.sink          in,
    output logic              q_valid,
    output iem_pkg::iem_item_t q_item,
    input  logic              q_pop
);
    import iem_pkg::*;

    iem_item_t  slot_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign in.ready = (cnt_reg != 2'd2);
    assign push     = in.valid && in.ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= '{op: in.op, word_addr: in.word_addr, wr_data: in.wr_data,
                                   page_index: in.page_index, read_len: in.read_len,
                                   sda_in: in.sda_in};
        end
    end

    // queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= ~wptr_reg;
            if (q_pop)
                rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end
endmodule

// ===== rtl/core/iem_back.sv =====
// back end: bus sequencer, page buffer and result register
module iem_back #(
    parameter int PAGE_BYTES = 8,
    parameter int MAX_READ   = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [iem_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [iem_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            q_valid,
    input  iem_pkg::iem_item_t              q_item,
    output logic                            q_pop,
    iem_result_if.source                    out
);
    import iem_pkg::*;

    localparam int PIDX_W = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;

    // configuration
    logic [6:0]  dev_addr_reg;
    logic [14:0] ack_timeout_reg;

    // sequencer state
    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] wait_count_reg, wait_count_next;
    logic [8:0]  byte_count_reg, byte_count_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic [7:0]  addr_reg, addr_next;
    logic [7:0]  data_reg, data_next;
    logic [8:0]  len_reg, len_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic [3:0]  end_status_reg, end_status_next;
    logic [1:0]  end_kind_reg, end_kind_next;
    logic [7:0]  page_buf [PAGE_BYTES];

    // result register
    logic        out_valid_reg;
    logic        busy_reg, rv_reg, rl_reg, done_reg;
    logic [7:0]  rd_reg;
    logic [3:0]  st_reg;
    logic [1:0]  fk_reg;

    logic        step;
    phase_t      ph;
    logic        busy, rv, rl, done;
    logic [7:0]  rd;
    logic [3:0]  st;
    logic [1:0]  fk;
    logic        pb_we;
    logic [PIDX_W-1:0] pb_widx, pb_ridx;
    logic [8:0]  rlen, seg_m1;
    logic [9:0]  byte_p1;
    logic        last_byte;

    assign step  = q_valid && (!out_valid_reg || out.ready);
    assign q_pop = step;

    assign pb_widx   = PIDX_W'(q_item.page_index);
    assign seg_m1    = byte_count_reg - 9'd1;
    assign byte_p1   = {1'b0, byte_count_reg} + 10'd1;
    assign last_byte = (byte_p1 >= {1'b0, len_reg});

    // next state for one tick
    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        wait_count_next = wait_count_reg;
        byte_count_next = byte_count_reg;
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        data_next       = data_reg;
        len_next        = len_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        end_status_next = end_status_reg;
        end_kind_next   = end_kind_reg;
        busy = 1'b0; rv = 1'b0; rl = 1'b0; done = 1'b0;
        rd = 8'd0; st = 4'd0; fk = FAIL_NONE;
        pb_we   = 1'b0;
        pb_ridx = '0;
        rlen    = q_item.read_len;
        ph      = phase_reg;

        // command decode while idle
        if (phase_reg == PH_IDLE)
        begin
            if (q_item.op == OP_LOAD)
            begin
                pb_we = (32'(q_item.page_index) < PAGE_BYTES);
            end
            else if (q_item.op == OP_BYTE_WR || q_item.op == OP_PAGE_WR ||
                     q_item.op == OP_READ)
            begin
                if (rlen == 9'd0)
                    rlen = 9'd1;
                if (32'(rlen) > MAX_READ)
                    rlen = 9'(MAX_READ);
                cmd_next        = q_item.op[1:0];
                addr_next       = q_item.word_addr;
                data_next       = q_item.wr_data;
                len_next        = rlen;
                byte_count_next = 9'd0;
                shift_next      = {dev_addr_reg, 1'b0};
                ph              = PH_STA;
            end
        end

        // one pin update
        if (ph != PH_IDLE)
        begin
            busy = 1'b1;
            unique case (ph)
                PH_STA: begin sda_next = 1'b1; phase_next = PH_STB; end
                PH_STB: begin scl_next = 1'b1; phase_next = PH_STC; end
                PH_STC: begin sda_next = 1'b0; phase_next = PH_STD; end
                PH_STD:
                begin
                    scl_next = 1'b0; bit_count_next = 4'd0; phase_next = PH_TXD;
                end
                PH_TXD: begin sda_next = shift_reg[7]; phase_next = PH_TXH; end
                PH_TXH: begin scl_next = 1'b1; phase_next = PH_TXL; end
                PH_TXL:
                begin
                    scl_next       = 1'b0;
                    shift_next     = {shift_reg[6:0], 1'b0};
                    bit_count_next = bit_count_reg + 4'd1;
                    phase_next     = (bit_count_next >= 4'd8) ? PH_TXE1 : PH_TXD;
                end
                PH_TXE1: begin scl_next = 1'b0; phase_next = PH_TXE2; end
                PH_TXE2:
                begin
                    sda_next = 1'b1; wait_count_next = 16'd0; phase_next = PH_AKW;
                end
                PH_AKW:
                begin
                    wait_count_next = wait_count_reg + 16'd1;
                    if (wait_count_next > {1'b0, ack_timeout_reg})
                    begin
                        end_status_next = byte_p1[3:0];
                        end_kind_next   = FAIL_TIMEOUT;
                        phase_next      = PH_SPA;
                    end
                    else if (!q_item.sda_in)
                        phase_next = PH_AKH;
                end
                PH_AKH:
                begin
                    scl_next = 1'b1;
                    if (q_item.sda_in)
                    begin
                        end_status_next = byte_p1[3:0];
                        end_kind_next   = FAIL_NACK;
                        phase_next      = PH_SPA;
                    end
                    else
                        phase_next = PH_AKL;
                end
                PH_AKL:
                begin
                    scl_next = 1'b0;
                    // choose the next segment of the transaction
                    priority if (byte_count_reg == 9'd0)
                    begin
                        byte_count_next = 9'd1;
                        shift_next = addr_reg; bit_count_next = 4'd0; phase_next = PH_TXD;
                    end
                    else if (byte_count_reg == 9'd1)
                    begin
                        byte_count_next = 9'd2;
                        if (cmd_reg == CMD_READ)
                        begin
                            shift_next = {dev_addr_reg, 1'b1}; phase_next = PH_STA;
                        end
                        else
                        begin
                            shift_next     = (cmd_reg == CMD_BYTE_WR) ? data_reg
                                                                      : page_buf[0];
                            bit_count_next = 4'd0;
                            phase_next     = PH_TXD;
                        end
                    end
                    else if (cmd_reg == CMD_READ)
                    begin
                        byte_count_next = 9'd0; phase_next = PH_RXR;
                    end
                    else if (cmd_reg != CMD_BYTE_WR && 32'(seg_m1) < PAGE_BYTES)
                    begin
                        pb_ridx         = seg_m1[PIDX_W-1:0];
                        byte_count_next = byte_p1[8:0];
                        shift_next      = page_buf[pb_ridx];
                        bit_count_next  = 4'd0;
                        phase_next      = PH_TXD;
                    end
                    else
                    begin
                        end_status_next = 4'd0; end_kind_next = FAIL_NONE;
                        phase_next      = PH_SPA;
                    end
                end
                PH_RXR:
                begin
                    sda_next = 1'b1; bit_count_next = 4'd0; shift_next = 8'd0;
                    phase_next = PH_RXH;
                end
                PH_RXH:
                begin
                    scl_next   = 1'b1;
                    shift_next = {shift_reg[6:0], q_item.sda_in};
                    phase_next = PH_RXL;
                end
                PH_RXL:
                begin
                    scl_next       = 1'b0;
                    bit_count_next = bit_count_reg + 4'd1;
                    phase_next     = (bit_count_next >= 4'd8) ? PH_RXA : PH_RXH;
                end
                PH_RXA: begin sda_next = last_byte; phase_next = PH_RXAH; end
                PH_RXAH: begin scl_next = 1'b1; phase_next = PH_RXAL; end
                PH_RXAL:
                begin
                    scl_next        = 1'b0;
                    rv              = 1'b1;
                    rd              = shift_reg;
                    rl              = last_byte;
                    byte_count_next = byte_p1[8:0];
                    if (last_byte)
                    begin
                        end_status_next = 4'd0; end_kind_next = FAIL_NONE;
                        phase_next      = PH_SPA;
                    end
                    else
                        phase_next = PH_RXR;
                end
                PH_SPA: begin sda_next = 1'b0; phase_next = PH_SPB; end
                PH_SPB: begin scl_next = 1'b1; phase_next = PH_SPC; end
                PH_SPC:
                begin
                    sda_next = 1'b1; done = 1'b1;
                    st = end_status_reg; fk = end_kind_reg;
                    phase_next = PH_IDLE;
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // page buffer
    always_ff @(posedge clk)
    begin
        if (step && pb_we)
            page_buf[pb_widx] <= q_item.wr_data;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg    <= DEV_ADDR_RST;
            ack_timeout_reg <= ACK_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_DEV_ADDR)
                dev_addr_reg <= cfg_data[6:0];
            else
                ack_timeout_reg <= cfg_data;
        end
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= 4'd0;
            shift_reg      <= 8'd0;
            wait_count_reg <= 16'd0;
            byte_count_reg <= 9'd0;
            cmd_reg        <= 2'd0;
            addr_reg       <= 8'd0;
            data_reg       <= 8'd0;
            len_reg        <= 9'd0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            end_status_reg <= 4'd0;
            end_kind_reg   <= FAIL_NONE;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            shift_reg      <= shift_next;
            wait_count_reg <= wait_count_next;
            byte_count_reg <= byte_count_next;
            cmd_reg        <= cmd_next;
            addr_reg       <= addr_next;
            data_reg       <= data_next;
            len_reg        <= len_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            end_status_reg <= end_status_next;
            end_kind_reg   <= end_kind_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            busy_reg <= busy; rv_reg <= rv; rd_reg <= rd; rl_reg <= rl;
            done_reg <= done; st_reg <= st; fk_reg <= fk;
        end
    end

    assign out.valid     = out_valid_reg;
    assign out.scl_out   = scl_reg;
    assign out.sda_out   = sda_reg;
    assign out.busy_res  = busy_reg;
    assign out.rd_valid  = rv_reg;
    assign out.rd_data   = rd_reg;
    assign out.rd_last   = rl_reg;
    assign out.done_res  = done_reg;
    assign out.status    = st_reg;
    assign out.fail_kind = fk_reg;
endmodule

// ===== rtl/core/i2c_eeprom_master_unit.sv =====
// top level of the i2c eeprom master
// Bit-banged I2C master for a small EEPROM: each request is one tick that makes at most
// one pin update on SCL/SDA and yields one result with the pin levels and status. Ticks
// pass a two-entry queue and then the single result register; the sequencer retires one
// per clock cycle while that register is empty or read, so a stream runs at one tick
// per cycle while out.ready is high, taking a tick in the same cycle a result leaves.
module i2c_eeprom_master_unit #(
    parameter int PAGE_BYTES = 8,
    parameter int MAX_READ   = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [iem_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [iem_pkg::CFG_DATA_W-1:0]  cfg_data,
    iem_item_if.sink                        in,
    iem_result_if.source                    out
);
    import iem_pkg::*;

    logic      q_valid, q_pop;
    iem_item_t q_item;

    // request queue
    iem_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in      (in),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    // bus sequencer
    iem_back #(
        .PAGE_BYTES (PAGE_BYTES),
        .MAX_READ   (MAX_READ)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out       (out)
    );
endmodule

// ===== rtl/core/iem_checker.sv =====
// port checks of the i2c eeprom master
module iem_port_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       busy_res,
    input logic       rd_valid,
    input logic [7:0] rd_data,
    input logic       rd_last,
    input logic       done_res,
    input logic [3:0] status,
    input logic [1:0] fail_kind
);
    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rd_data) && $stable(status))
        else $error("result changed while stalled");

    // done and received bytes only inside a transaction
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (done_res || rd_valid) |-> busy_res)
        else $error("done or read byte outside a transaction");

    // read fields are clear without a read byte
    a_rd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !rd_valid |-> rd_data == 8'd0 && !rd_last)
        else $error("read fields set without read byte");

    // status only on the done tick
    a_st: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> status == 4'd0 && fail_kind == 2'd0)
        else $error("status set outside done tick");
endmodule

bind i2c_eeprom_master_unit iem_port_checker u_iem_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out.valid),
    .out_ready (out.ready),
    .busy_res  (out.busy_res),
    .rd_valid  (out.rd_valid),
    .rd_data   (out.rd_data),
    .rd_last   (out.rd_last),
    .done_res  (out.done_res),
    .status    (out.status),
    .fail_kind (out.fail_kind)
);
